// ----- rtl/core/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
// Holds the status codes, the decoded job record and the hex digit decoder.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Result status codes
    localparam logic [2:0] ST_DATA   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_NOSTR  = 3'd2;
    localparam logic [2:0] ST_BADESC = 3'd3;
    localparam logic [2:0] ST_BADHEX = 3'd4;
    localparam logic [2:0] ST_UNTERM = 3'd5;

    // UTF-8 framing constants
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One input byte's worth of results: up to three bytes, one status.
    typedef struct packed {
        logic [1:0] last_idx;
        logic [2:0] status;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            h.val = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            h.val = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            h.val = 4'(c - 8'h37);
        else
            h.ok = 1'b0;
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jsu_front.sv -----
// Front end of the unescaper: accepts source bytes, tracks the string
// state and turns each byte into a job of zero to three results. Uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    output logic            push,
    output job_t            job
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [11:0] hex_value_reg, hex_value_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;

    hex_t        hd;
    logic [15:0] code;

    assign hd   = hex_digit(in_byte);
    assign code = {hex_value_reg, hd.val};

    always_comb
    begin
        phase_next     = phase_reg;
        hex_value_next = hex_value_reg;
        hex_cnt_next   = hex_cnt_reg;
        push           = 1'b0;
        job            = '0;
        job.status     = ST_DATA;
        unique case (phase_reg)
            PH_STR:
            begin
                push = 1'b1;
                if (in_byte == 8'h00)
                begin
                    job.status = ST_UNTERM;
                    phase_next = PH_IDLE;
                end
                else if (in_byte == 8'h22)
                begin
                    job.status = ST_DONE;
                    phase_next = PH_IDLE;
                end
                else if (in_byte == 8'h5C)
                begin
                    push       = 1'b0;
                    phase_next = PH_ESC;
                end
                else
                begin
                    job.b0 = in_byte;
                end
            end
            PH_ESC:
            begin
                push       = 1'b1;
                phase_next = PH_STR;
                unique case (in_byte)
                    8'h22:   job.b0 = 8'h22;
                    8'h5C:   job.b0 = 8'h5C;
                    8'h2F:   job.b0 = 8'h2F;
                    8'h62:   job.b0 = 8'h08;
                    8'h66:   job.b0 = 8'h0C;
                    8'h6E:   job.b0 = 8'h0A;
                    8'h72:   job.b0 = 8'h0D;
                    8'h74:   job.b0 = 8'h09;
                    8'h75:
                    begin
                        push           = 1'b0;
                        phase_next     = PH_HEX;
                        hex_value_next = '0;
                        hex_cnt_next   = '0;
                    end
                    default:
                    begin
                        job.status = ST_BADESC;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            PH_HEX:
            begin
                if (!hd.ok)
                begin
                    push           = 1'b1;
                    job.status     = ST_BADHEX;
                    phase_next     = PH_IDLE;
                    hex_value_next = '0;
                    hex_cnt_next   = '0;
                end
                else if (hex_cnt_reg != 2'd3)
                begin
                    hex_value_next = code[11:0];
                    hex_cnt_next   = hex_cnt_reg + 2'd1;
                end
                else
                begin
                    push           = 1'b1;
                    phase_next     = PH_STR;
                    hex_value_next = '0;
                    hex_cnt_next   = '0;
                    if (code < UTF8_LIM1)
                    begin
                        job.b0 = code[7:0];
                    end
                    else if (code < UTF8_LIM2)
                    begin
                        job.last_idx = 2'd1;
                        job.b0 = UTF8_LEAD2 | {3'b000, code[10:6]};
                        job.b1 = UTF8_CONT | ({2'b00, code[5:0]} & UTF8_MASK);
                    end
                    else
                    begin
                        job.last_idx = 2'd2;
                        job.b0 = UTF8_LEAD3 | {4'h0, code[15:12]};
                        job.b1 = UTF8_CONT | ({2'b00, code[11:6]} & UTF8_MASK);
                        job.b2 = UTF8_CONT | ({2'b00, code[5:0]} & UTF8_MASK);
                    end
                end
            end
            default:
            begin
                // Idle: wait for the opening quote; any other byte yields a no-string result
                if (in_byte == 8'h22)
                begin
                    phase_next     = PH_STR;
                    hex_value_next = '0;
                    hex_cnt_next   = '0;
                end
                else
                begin
                    push       = 1'b1;
                    job.status = ST_NOSTR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hex_value_reg <= '0;
            hex_cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hex_value_reg <= hex_value_next;
            hex_cnt_reg   <= hex_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/jsu_queue.sv -----
// Short job queue between the front end and the emitter.
// Holds QDEPTH jobs of type job_t from jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      nonempty,
    output job_t      head
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full     = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/jsu_back.sv -----
// Unescaper emitter: walks the head job of the queue one byte per cycle,
// unless stalled, into the output register. Uses job_t and jsu_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    input  wire job_t       job,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [2:0]      status,
    output logic            last
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] status_reg;
    logic       last_reg;
    logic [1:0] idx_reg;

    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = job_valid && (!out_valid_reg || !out_stall);
    assign at_end = (idx_reg == job.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = job.b0;
            2'd1:    sel_byte = job.b1;
            default: sel_byte = job.b2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= sel_byte;
            status_reg   <= job.status;
            last_reg     <= at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/json_string_unescaper.sv -----
// JSON string unescaper: takes a string literal byte by byte, starting at
// its opening quote, and emits the decoded bytes, then a completion or error
// result. A new source byte is taken every cycle; each result leaves on its
// own cycle, so a byte that decodes to several results holds the output for
// each of them (a \u escape at or above U+0800 yields three). A four-entry
// job queue between the decoder and the emitter absorbs such runs; the input
// stalls only while that queue is full. Results pass through the job queue
// and the output register. Uses jsu_pkg, jsu_front, jsu_queue and jsu_back.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [2:0]      status,
    output logic            last
);

    logic accept;
    logic front_push;
    logic q_push;
    logic q_full;
    logic q_nonempty;
    logic q_pop;
    job_t front_job;
    job_t head_job;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept && front_push;

    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (front_push),
        .job     (front_job)
    );

    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (head_job)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_nonempty),
        .job       (head_job),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DATA) |-> (last && out_byte == 8'h00))
        else $error("non-data result not final or carries a byte");

    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside a multi-byte run");
`endif

endmodule

`default_nettype wire

// ----- test/tb_json_string_unescaper.sv -----
// Testbench for json_string_unescaper: drives JSON string literals byte by byte
// and checks every decoded byte, completion and error result against a local decoder.
// Depends on jsu_pkg for the status codes and UTF-8 framing constants.
`timescale 1ns / 1ps

module tb_json_string_unescaper;
    import jsu_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         RANDOM_BYTES  = 330;
    localparam int         DRAIN_CYCLES  = 12;
    localparam int         REPORT_MAX    = 10;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_NUL        = 8'h00;

    typedef enum logic [1:0] {DEC_IDLE, DEC_STR, DEC_ESC, DEC_HEX} dec_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] st;
        logic       fin;
    } dec_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    // decoder state mirrored by the testbench
    dec_phase_t  dec_phase;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    dec_result_t decoded_q[$];

    dec_result_t want;
    int          mismatch_cnt;
    int          cycle_cnt;
    int          bytes_sent;
    bit          calm;

    json_string_unescaper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_json_string_unescaper: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 12);
    end

    // ---------------------------------------------------------------- decoder

    function automatic void emit(input logic [7:0] b, input logic [2:0] st,
                                 input logic fin);
        decoded_q.push_back(dec_result_t'{b, st, fin});
    endfunction

    function automatic void abort_string(input logic [2:0] st);
        emit(8'h00, st, 1'b1);
        dec_phase = DEC_IDLE;
        hex_acc   = '0;
        hex_cnt   = '0;
    endfunction

    // bit 8 set when c names a single-byte escape
    function automatic logic [8:0] unescape(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            "/":       return {1'b1, 8'h2F};
            "b":       return {1'b1, 8'h08};
            "f":       return {1'b1, 8'h0C};
            "n":       return {1'b1, 8'h0A};
            "r":       return {1'b1, 8'h0D};
            "t":       return {1'b1, 8'h09};
            default:   return {1'b0, 8'h00};
        endcase
    endfunction

    // bit 4 set when c is not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
            d = c - 8'h30;
        else if (c >= "a" && c <= "f")
            d = c - 8'h57;
        else if (c >= "A" && c <= "F")
            d = c - 8'h37;
        else
            return 5'h10;
        return {1'b0, d[3:0]};
    endfunction

    function automatic void decode_byte(input logic [7:0] c);
        logic [4:0]  nib;
        logic [8:0]  esc;
        logic [15:0] cp;
        case (dec_phase)
            DEC_STR:
            begin
                if (c == CH_NUL)
                    abort_string(ST_UNTERM);
                else if (c == CH_QUOTE)
                begin
                    emit(8'h00, ST_DONE, 1'b1);
                    dec_phase = DEC_IDLE;
                end
                else if (c == CH_BSLASH)
                    dec_phase = DEC_ESC;
                else
                    emit(c, ST_DATA, 1'b1);
            end
            DEC_ESC:
            begin
                esc = unescape(c);
                if (c == "u")
                begin
                    dec_phase = DEC_HEX;
                    hex_acc   = '0;
                    hex_cnt   = '0;
                end
                else if (!esc[8])
                    abort_string(ST_BADESC);
                else
                begin
                    emit(esc[7:0], ST_DATA, 1'b1);
                    dec_phase = DEC_STR;
                end
            end
            DEC_HEX:
            begin
                nib = nibble_of(c);
                if (nib[4])
                    abort_string(ST_BADHEX);
                else
                begin
                    cp = {hex_acc[11:0], nib[3:0]};
                    if (hex_cnt < 2'd3)
                    begin
                        hex_acc = cp;
                        hex_cnt = hex_cnt + 2'd1;
                    end
                    else
                    begin
                        hex_acc   = '0;
                        hex_cnt   = '0;
                        dec_phase = DEC_STR;
                        // surrogates are encoded as plain three-byte code points
                        if (cp < UTF8_LIM1)
                            emit(cp[7:0], ST_DATA, 1'b1);
                        else if (cp < UTF8_LIM2)
                        begin
                            emit(UTF8_LEAD2 | {3'b0, cp[10:6]}, ST_DATA, 1'b0);
                            emit(UTF8_CONT | {2'b0, cp[5:0]}, ST_DATA, 1'b1);
                        end
                        else
                        begin
                            emit(UTF8_LEAD3 | {4'b0, cp[15:12]}, ST_DATA, 1'b0);
                            emit(UTF8_CONT | {2'b0, cp[11:6]}, ST_DATA, 1'b0);
                            emit(UTF8_CONT | {2'b0, cp[5:0]}, ST_DATA, 1'b1);
                        end
                    end
                end
            end
            default:
            begin
                if (c != CH_QUOTE)
                    emit(8'h00, ST_NOSTR, 1'b1);
                else
                begin
                    dec_phase = DEC_STR;
                    hex_acc   = '0;
                    hex_cnt   = '0;
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result byte %02h status %0d last %0b",
                             $realtime, out_byte, status, last);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data || status !== want.st || last !== want.fin)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: expected byte %02h status %0d last %0b, got %02h %0d %0b",
                                 $realtime, want.data, want.st, want.fin,
                                 out_byte, status, last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'b0, nib};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'b0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter(input int idx);
        case (idx)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    task automatic send_unicode(input logic [15:0] cp);
        send_byte(CH_BSLASH);
        send_byte("u");
        send_byte(hex_char(cp[15:12]));
        send_byte(hex_char(cp[11:8]));
        send_byte(hex_char(cp[7:4]));
        send_byte(hex_char(cp[3:0]));
    endtask

    // one well-formed piece of string content
    task automatic send_piece();
        int          kind;
        logic [7:0]  b;
        logic [15:0] cp;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == CH_QUOTE || b == CH_BSLASH);
            send_byte(b);
        end
        else if (kind < 7)
        begin
            send_byte(CH_BSLASH);
            send_byte(escape_letter($urandom_range(0, 7)));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                default: cp = $urandom_range(0, 1) ? 16'h0800 : 16'h07FF;
            endcase
            send_unicode(cp);
        end
    endtask

    task automatic send_pieces(input int max_n);
        repeat ($urandom_range(0, max_n))
            send_piece();
    endtask

    task automatic send_broken();
        logic [7:0] b;
        logic [4:0] nb;
        case ($urandom_range(0, 4))
            0:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE);
                send_byte(b);
            end
            1:
            begin
                send_byte(CH_QUOTE);
                send_pieces(4);
                send_byte(CH_NUL);
            end
            2:
            begin
                send_byte(CH_QUOTE);
                send_pieces(3);
                send_byte(CH_BSLASH);
                do
                    b = 8'($urandom_range(0, 255));
                while (unescape(b) != 9'h000 || b == "u");
                send_byte(b);
            end
            3:
            begin
                send_byte(CH_QUOTE);
                send_pieces(3);
                send_byte(CH_BSLASH);
                send_byte("u");
                repeat ($urandom_range(0, 3))
                    send_byte(hex_char(4'($urandom_range(0, 15))));
                do
                begin
                    b  = 8'($urandom_range(0, 255));
                    nb = nibble_of(b);
                end
                while (!nb[4]);
                send_byte(b);
            end
            default:
            begin
                send_byte(CH_QUOTE);
                send_pieces(3);
                send_byte(CH_BSLASH);
                send_byte(CH_NUL);
            end
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_idle_rejects();
        send_byte(CH_NUL);
        send_byte("a");
        send_byte(8'hFF);
    endtask

    task automatic test_plain_and_escapes();
        send_byte(CH_QUOTE);
        send_byte(8'h01);
        send_byte(8'h7F);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(CH_BSLASH);
            send_byte(escape_letter(i));
        end
        send_byte(CH_QUOTE);
    endtask

    task automatic test_unicode_lengths();
        send_byte(CH_QUOTE);
        send_unicode(16'h0000);
        send_unicode(16'h07FF);
        send_unicode(16'h0800);
        send_unicode(16'hFFFF);
        send_byte(CH_QUOTE);
    endtask

    task automatic test_error_cases();
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte("q");
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_NUL);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte("u");
        send_byte("G");
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte("u");
        send_byte("1");
        send_byte(CH_NUL);
        send_byte(CH_QUOTE);
        send_byte(CH_NUL);
    endtask

    task automatic test_random_strings();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            // hold a stretch in the middle with no idling on either side
            calm = (bytes_sent - start >= 150) && (bytes_sent - start < 250);
            if ($urandom_range(0, 99) < 85)
            begin
                send_byte(CH_QUOTE);
                send_pieces(8);
                send_byte(CH_QUOTE);
            end
            else
                send_broken();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        out_stall    = 1'b0;
        calm         = 1'b0;
        dec_phase    = DEC_IDLE;
        hex_acc      = '0;
        hex_cnt      = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        bytes_sent   = 0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_rejects();
        test_plain_and_escapes();
        test_unicode_lengths();
        test_error_cases();
        test_random_strings();
        in_valid <= 1'b0;

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("tb_json_string_unescaper: PASS");
        else
            $display("tb_json_string_unescaper: FAIL");
        $finish;
    end

endmodule
